[sv/ats_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

    localparam int NUM_HAPS_DEF = 1024;
    localparam int QUEUE_DEPTH  = 4;

    localparam int HAP_W     = 10;
    localparam int HAP_EXT_W = 17;
    localparam int POS_W     = 32;
    localparam int ANC_W     = 8;
    localparam int CHROM_W   = 8;
    localparam int ENTRY_W   = ANC_W + POS_W;

    localparam logic [ANC_W-1:0] MISSING_ANC = 8'd255;

    typedef enum logic [1:0] {
        K_FIRST    = 2'd0,
        K_NEWCHROM = 2'd1,
        K_NORMAL   = 2'd2,
        K_CLOSE    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [HAP_W-1:0]   hap;
        logic [ANC_W-1:0]   anc;
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   end_pos;
    } cmd_t;

endpackage

`default_nettype wire

[sv/ats_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ats_front #(
    parameter int NUM_HAPS = ats_pkg::NUM_HAPS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        action,
    input  wire logic [ats_pkg::HAP_W-1:0]   hap_index,
    input  wire logic                        site_start,
    input  wire logic [ats_pkg::CHROM_W-1:0] chrom_id,
    input  wire logic [ats_pkg::POS_W-1:0]   position,
    input  wire logic [ats_pkg::ANC_W-1:0]   ancestry,
    input  wire logic                        q_ready,
    output logic                             q_push,
    output ats_pkg::cmd_t                    q_cmd
);
    import ats_pkg::*;

    logic [POS_W-1:0]   now_reg,   now_next;
    logic [POS_W-1:0]   mid_reg,   mid_next;
    logic [CHROM_W-1:0] chrom_now_reg,   chrom_now_next;
    logic [CHROM_W-1:0] chrom_closing_reg, chrom_closing_next;
    logic               first_site_reg,  first_site_next;
    kind_t              site_kind_reg,   site_kind_next;

    logic             accept;
    logic             in_range;
    logic             site_upd;
    logic [POS_W-1:0] mid_calc;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign in_range = {{(HAP_EXT_W-HAP_W){1'b0}}, hap_index} < HAP_EXT_W'(NUM_HAPS);
    assign site_upd = accept && !action && (site_start || first_site_reg);
    assign mid_calc = now_reg + ((position - now_reg) >> 1);

    always_comb
    begin
        now_next           = now_reg;
        mid_next           = mid_reg;
        chrom_now_next     = chrom_now_reg;
        chrom_closing_next = chrom_closing_reg;
        first_site_next    = first_site_reg;
        site_kind_next     = site_kind_reg;
        if (site_upd)
        begin
            now_next = position;
            mid_next = mid_calc;
            if (first_site_reg)
            begin
                first_site_next = 1'b0;
                site_kind_next  = K_FIRST;
                chrom_now_next  = chrom_id;
            end
            else if (chrom_id != chrom_now_reg)
            begin
                site_kind_next     = K_NEWCHROM;
                chrom_closing_next = chrom_now_reg;
                chrom_now_next     = chrom_id;
            end
            else
            begin
                site_kind_next = K_NORMAL;
            end
        end
    end

    // build the request from the site state as it stands after this item
    always_comb
    begin
        q_cmd.hap = hap_index;
        q_cmd.anc = ancestry;
        if (action)
        begin
            q_cmd.kind    = K_CLOSE;
            q_cmd.chrom   = chrom_now_reg;
            q_cmd.end_pos = now_reg;
        end
        else
        begin
            q_cmd.kind = site_kind_next;
            unique case (site_kind_next)
                K_NEWCHROM:
                begin
                    q_cmd.chrom   = chrom_closing_next;
                    q_cmd.end_pos = now_next - POS_W'(1);
                end
                K_NORMAL:
                begin
                    q_cmd.chrom   = chrom_now_next;
                    q_cmd.end_pos = mid_next;
                end
                default:
                begin
                    // first site: end + 1 gives the opening position
                    q_cmd.chrom   = chrom_now_next;
                    q_cmd.end_pos = now_next - POS_W'(1);
                end
            endcase
        end
    end

    assign q_push = accept && in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg           <= '0;
            mid_reg           <= '0;
            chrom_now_reg     <= '0;
            chrom_closing_reg <= '0;
            first_site_reg    <= 1'b1;
            site_kind_reg     <= K_NORMAL;
        end
        else
        begin
            now_reg           <= now_next;
            mid_reg           <= mid_next;
            chrom_now_reg     <= chrom_now_next;
            chrom_closing_reg <= chrom_closing_next;
            first_site_reg    <= first_site_next;
            site_kind_reg     <= site_kind_next;
        end
    end

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_site_reg) |-> $past(accept && !action))
        else $error("first-site flag cleared without an accepted call");

    a_first_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (site_upd && first_site_reg) |=> (site_kind_reg == K_FIRST))
        else $error("first site not marked as first");

    a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("request pushed into a full queue");

endmodule

`default_nettype wire

[sv/ats_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ats_queue #(
    parameter int DEPTH = ats_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  ats_pkg::cmd_t      push_cmd,
    output logic               not_full,
    input  wire logic          pop,
    output logic               not_empty,
    output ats_pkg::cmd_t      head_cmd
);
    import ats_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign not_full  = count_reg != CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> not_full)
        else $error("queue pushed while full");

endmodule

`default_nettype wire

[sv/ats_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ats_back #(
    parameter int NUM_HAPS = ats_pkg::NUM_HAPS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  ats_pkg::cmd_t                     q_cmd,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ats_pkg::HAP_W-1:0]         tract_hap,
    output logic [ats_pkg::CHROM_W-1:0]       tract_chrom,
    output logic [ats_pkg::POS_W-1:0]         start_pos,
    output logic [ats_pkg::POS_W-1:0]         end_pos,
    output logic [ats_pkg::ANC_W-1:0]         tract_ancestry
);
    import ats_pkg::*;

    localparam int HAP_AW = $clog2(NUM_HAPS);

    logic [ENTRY_W-1:0] tract_mem [NUM_HAPS];

    logic               s1_valid_reg, s1_valid_next;
    cmd_t               s1_cmd_reg;
    logic [ENTRY_W-1:0] s1_old_reg;

    logic               out_valid_reg, out_valid_next;
    logic [HAP_W-1:0]   out_hap_reg;
    logic [CHROM_W-1:0] out_chrom_reg;
    logic [POS_W-1:0]   out_start_reg;
    logic [POS_W-1:0]   out_end_reg;
    logic [ANC_W-1:0]   out_anc_reg;

    logic [ANC_W-1:0]   old_anc;
    logic [POS_W-1:0]   old_start;
    logic               s1_emit;
    logic               s1_wr;
    logic               s1_adv;
    logic               s1_done;
    logic               s1_load;
    logic [HAP_AW-1:0]  wr_idx;
    logic [HAP_AW-1:0]  ld_idx;
    logic [ENTRY_W-1:0] wr_data;
    logic [HAP_EXT_W-1:0] wr_hap_ext;
    logic [HAP_EXT_W-1:0] ld_hap_ext;

    assign old_anc   = s1_old_reg[ENTRY_W-1:POS_W];
    assign old_start = s1_old_reg[POS_W-1:0];

    always_comb
    begin
        unique case (s1_cmd_reg.kind)
            K_FIRST:
            begin
                s1_emit = 1'b0;
                s1_wr   = 1'b1;
            end
            K_NEWCHROM:
            begin
                s1_emit = old_anc != MISSING_ANC;
                s1_wr   = 1'b1;
            end
            K_NORMAL:
            begin
                s1_emit = s1_cmd_reg.anc != old_anc;
                s1_wr   = s1_cmd_reg.anc != old_anc;
            end
            K_CLOSE:
            begin
                s1_emit = old_anc != MISSING_ANC;
                s1_wr   = 1'b0;
            end
            default:
            begin
                s1_emit = 1'b0;
                s1_wr   = 1'b0;
            end
        endcase
    end

    assign s1_adv  = !s1_emit || !out_valid_reg || out_ready;
    assign s1_done = s1_valid_reg && s1_adv;
    assign s1_load = q_valid && (!s1_valid_reg || s1_done);
    assign q_pop   = s1_load;

    assign wr_hap_ext = {{(HAP_EXT_W-HAP_W){1'b0}}, s1_cmd_reg.hap};
    assign ld_hap_ext = {{(HAP_EXT_W-HAP_W){1'b0}}, q_cmd.hap};
    assign wr_idx     = wr_hap_ext[HAP_AW-1:0];
    assign ld_idx     = ld_hap_ext[HAP_AW-1:0];
    // the new tract opens just after the end position carried in the request
    assign wr_data    = {s1_cmd_reg.anc, s1_cmd_reg.end_pos + POS_W'(1)};

    always_ff @(posedge clk)
    begin
        if (s1_done && s1_wr)
        begin
            tract_mem[wr_idx] <= wr_data;
        end
    end

    // forward the entry being written when the next request hits the same haplotype
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cmd_reg <= q_cmd;
            if (s1_done && s1_wr && (wr_idx == ld_idx))
            begin
                s1_old_reg <= wr_data;
            end
            else
            begin
                s1_old_reg <= tract_mem[ld_idx];
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_done && s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done && s1_emit)
        begin
            out_hap_reg   <= s1_cmd_reg.hap;
            out_chrom_reg <= s1_cmd_reg.chrom;
            out_start_reg <= old_start;
            out_end_reg   <= s1_cmd_reg.end_pos;
            out_anc_reg   <= old_anc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tract_hap      = out_hap_reg;
    assign tract_chrom    = out_chrom_reg;
    assign start_pos      = out_start_reg;
    assign end_pos        = out_end_reg;
    assign tract_ancestry = out_anc_reg;

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_done && s1_emit) |=> out_valid_reg)
        else $error("finished tract did not reach the output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit && out_valid_reg && !out_ready) |-> !s1_done)
        else $error("pending result overwritten");

    a_close_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_cmd_reg.kind == K_CLOSE) |-> !s1_wr)
        else $error("close request wrote the tract store");

endmodule

`default_nettype wire

[sv/ancestry_tract_segmenter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  action, hap_index, site_start, chrom_id,
//                                           position, ancestry
// output    out        out_valid/out_ready  tract_hap, tract_chrom, start_pos, end_pos,
//                                           tract_ancestry
//
// One request per cycle unless the output stalls; the tract output is registered.
// The rate is set by the single read-modify-write of the per-haplotype tract store,
// with the entry being written forwarded to a following request on the same haplotype.
// Reset clears the site state and the queue; the tract store needs no clearing pass.
// An output stall fills the four-entry queue, after which in_ready drops.

module ancestry_tract_segmenter #(
    parameter int NUM_HAPS = ats_pkg::NUM_HAPS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        action,
    input  wire logic [ats_pkg::HAP_W-1:0]   hap_index,
    input  wire logic                        site_start,
    input  wire logic [ats_pkg::CHROM_W-1:0] chrom_id,
    input  wire logic [ats_pkg::POS_W-1:0]   position,
    input  wire logic [ats_pkg::ANC_W-1:0]   ancestry,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ats_pkg::HAP_W-1:0]        tract_hap,
    output logic [ats_pkg::CHROM_W-1:0]      tract_chrom,
    output logic [ats_pkg::POS_W-1:0]        start_pos,
    output logic [ats_pkg::POS_W-1:0]        end_pos,
    output logic [ats_pkg::ANC_W-1:0]        tract_ancestry
);
    import ats_pkg::*;

    logic q_push;
    logic q_not_full;
    logic q_pop;
    logic q_not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    ats_front #(
        .NUM_HAPS (NUM_HAPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .hap_index  (hap_index),
        .site_start (site_start),
        .chrom_id   (chrom_id),
        .position   (position),
        .ancestry   (ancestry),
        .q_ready    (q_not_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    ats_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    ats_back #(
        .NUM_HAPS (NUM_HAPS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_not_empty),
        .q_cmd          (head_cmd),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tract_hap      (tract_hap),
        .tract_chrom    (tract_chrom),
        .start_pos      (start_pos),
        .end_pos        (end_pos),
        .tract_ancestry (tract_ancestry)
    );

endmodule

`default_nettype wire
